@@ rtl/sams_pkg.sv @@
// Shared types, sizes and codes for the shared-array multi-stack block.
package sams_pkg;

    localparam int CAPACITY   = 64;
    localparam int NUM_STACKS = 4;
    localparam int SLICE      = CAPACITY / NUM_STACKS;
    localparam int WORD_W     = 32;
    localparam int AW         = $clog2(CAPACITY);
    localparam int PW         = $clog2(CAPACITY + 1);
    localparam int BIW        = $clog2(NUM_STACKS + 1);
    localparam int TIW        = $clog2(NUM_STACKS);

    typedef logic [PW-1:0]  t_ptr;
    typedef logic [BIW-1:0] t_bidx;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOROOM   = 2'd2;
    localparam logic [1:0] ST_BADSTACK = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [2:0]         stack_sel;
        logic signed [31:0] push_value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
    } t_result;

endpackage

@@ rtl/shared_array_multi_stack.sv @@
// Several stacks sharing one word memory, repacked when a push finds its stack full.
// Pop: S_CHECK, S_POP_RD, S_FIN; plain push: S_CHECK, S_PUSH, S_FIN; bad stack or empty
// pop: S_CHECK, S_FIN. A push onto a full stack first passes over the other stacks in
// S_UP_CHK and S_DN_CHK, moving words; every move is a read (S_MV_RD) then a write (S_MV_WR)
// through the word RAM. One item in flight; o_stall is high until the result loads.
// Synchronous active-low reset splits the memory evenly and empties every stack, RAM untouched.
module shared_array_multi_stack
    import sams_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_UP_CHK = 4'd2;
    localparam logic [3:0] S_DN_CHK = 4'd3;
    localparam logic [3:0] S_MV_RD  = 4'd4;
    localparam logic [3:0] S_MV_WR  = 4'd5;
    localparam logic [3:0] S_PUSH   = 4'd6;
    localparam logic [3:0] S_POP_RD = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_op, n_op;
    logic       r_bad, n_bad;
    t_bidx      r_k, n_k;
    logic [WORD_W-1:0] r_val, n_val;
    t_bidx      r_idx, n_idx;
    t_ptr       r_ptr, n_ptr;
    logic       r_up, n_up;
    t_result    r_res, n_res;
    t_ptr       r_bnd [NUM_STACKS+1];
    t_ptr       n_bnd [NUM_STACKS+1];
    t_ptr       r_top [NUM_STACKS];
    t_ptr       n_top [NUM_STACKS];
    logic       r_ovalid, n_ovalid;
    t_result    r_out, n_out;

    logic [NUM_STACKS-1:0] full_v;
    logic [NUM_STACKS-1:0] order_ok;
    logic [TIW-1:0]        idx_t, idm1_t, k_t;
    logic                  in_xfer, out_free;
    t_ptr                  ptr_dec, ptr_inc, top_k_dec;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_wa, ram_ra;
    logic [WORD_W-1:0]     ram_wd, ram_rd;

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign o_valid  = r_ovalid;
    assign o_result = r_out;

    assign idx_t     = r_idx[TIW-1:0];
    assign idm1_t    = TIW'(r_idx - 1'b1);
    assign k_t       = r_k[TIW-1:0];
    assign ptr_dec   = t_ptr'(r_ptr - 1'b1);
    assign ptr_inc   = t_ptr'(r_ptr + 1'b1);
    assign top_k_dec = t_ptr'(r_top[k_t] - 1'b1);

    // Fullness and ordering of each stack
    always_comb begin
        for (int i = 0; i < NUM_STACKS; i++) begin
            full_v[i]   = (r_top[i] >= r_bnd[i+1]);
            order_ok[i] = (r_bnd[i] <= r_top[i]) && (r_top[i] <= r_bnd[i+1]);
        end
    end

    // Word memory
    sams_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_word_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_bad   = r_bad;
        n_k     = r_k;
        n_val   = r_val;
        n_idx   = r_idx;
        n_ptr   = r_ptr;
        n_up    = r_up;
        n_res   = r_res;
        n_bnd   = r_bnd;
        n_top   = r_top;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        ram_wa  = r_ptr[AW-1:0];
        ram_ra  = r_ptr[AW-1:0];
        ram_wd  = ram_rd;

        unique case (r_state)
            S_IDLE: begin
                // Take the item
                if (in_xfer) begin
                    n_op    = i_item.opcode;
                    n_bad   = (32'(i_item.stack_sel) >= NUM_STACKS);
                    n_k     = t_bidx'(i_item.stack_sel);
                    n_val   = i_item.push_value;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_res.pop_value = '0;
                if (r_bad) begin
                    n_res.status = ST_BADSTACK;
                    n_state      = S_FIN;
                end else if (r_op == OP_POP) begin
                    if (r_top[k_t] <= r_bnd[r_k]) begin
                        n_res.status = ST_EMPTY;
                        n_state      = S_FIN;
                    end else begin
                        n_top[k_t] = top_k_dec;
                        ram_re     = 1'b1;
                        ram_ra     = top_k_dec[AW-1:0];
                        n_state    = S_POP_RD;
                    end
                end else if (full_v[k_t]) begin
                    n_idx   = t_bidx'(NUM_STACKS - 1);
                    n_state = S_UP_CHK;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_POP_RD: begin
                n_res.pop_value = ram_rd;
                n_res.status    = ST_OK;
                n_state         = S_FIN;
            end
            S_UP_CHK: begin
                // Shift stacks above the selected one up, top stack first
                if (r_idx > r_k) begin
                    if (!full_v[idx_t]) begin
                        if (r_top[idx_t] > r_bnd[r_idx]) begin
                            n_ptr   = r_top[idx_t];
                            n_up    = 1'b1;
                            n_state = S_MV_RD;
                        end else begin
                            n_bnd[r_idx] = t_ptr'(r_bnd[r_idx] + 1'b1);
                            n_top[idx_t] = t_ptr'(r_top[idx_t] + 1'b1);
                            n_idx        = t_bidx'(r_idx - 1'b1);
                        end
                    end else begin
                        n_idx = t_bidx'(r_idx - 1'b1);
                    end
                end else if (full_v[k_t]) begin
                    n_idx   = t_bidx'(1);
                    n_state = S_DN_CHK;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_DN_CHK: begin
                // Shift stacks from stack one up to the selected one down
                if (r_idx <= r_k) begin
                    if (!full_v[idm1_t]) begin
                        if (r_top[idx_t] > r_bnd[r_idx]) begin
                            n_ptr   = r_bnd[r_idx];
                            n_up    = 1'b0;
                            n_state = S_MV_RD;
                        end else begin
                            n_bnd[r_idx] = t_ptr'(r_bnd[r_idx] - 1'b1);
                            n_top[idx_t] = t_ptr'(r_top[idx_t] - 1'b1);
                            n_idx        = t_bidx'(r_idx + 1'b1);
                        end
                    end else begin
                        n_idx = t_bidx'(r_idx + 1'b1);
                    end
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_MV_RD: begin
                ram_re  = 1'b1;
                ram_ra  = r_up ? ptr_dec[AW-1:0] : r_ptr[AW-1:0];
                n_state = S_MV_WR;
            end
            S_MV_WR: begin
                // Write the moved word and advance
                ram_we = 1'b1;
                ram_wd = ram_rd;
                if (r_up) begin
                    ram_wa = r_ptr[AW-1:0];
                    n_ptr  = ptr_dec;
                    if (ptr_dec == r_bnd[r_idx]) begin
                        n_bnd[r_idx] = t_ptr'(r_bnd[r_idx] + 1'b1);
                        n_top[idx_t] = t_ptr'(r_top[idx_t] + 1'b1);
                        n_idx        = t_bidx'(r_idx - 1'b1);
                        n_state      = S_UP_CHK;
                    end else begin
                        n_state = S_MV_RD;
                    end
                end else begin
                    ram_wa = ptr_dec[AW-1:0];
                    n_ptr  = ptr_inc;
                    if (ptr_inc == r_top[idx_t]) begin
                        n_bnd[r_idx] = t_ptr'(r_bnd[r_idx] - 1'b1);
                        n_top[idx_t] = t_ptr'(r_top[idx_t] - 1'b1);
                        n_idx        = t_bidx'(r_idx + 1'b1);
                        n_state      = S_DN_CHK;
                    end else begin
                        n_state = S_MV_RD;
                    end
                end
            end
            S_PUSH: begin
                n_res.pop_value = '0;
                if (!full_v[k_t]) begin
                    ram_we       = 1'b1;
                    ram_wa       = r_top[k_t][AW-1:0];
                    ram_wd       = r_val;
                    n_top[k_t]   = t_ptr'(r_top[k_t] + 1'b1);
                    n_res.status = ST_OK;
                end else begin
                    n_res.status = ST_NOROOM;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        n_ovalid = r_ovalid;
        n_out    = r_out;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        if (r_state == S_FIN && out_free) begin
            n_ovalid = 1'b1;
            n_out    = r_res;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i <= NUM_STACKS; i++) begin
                r_bnd[i] <= t_ptr'(i * SLICE);
            end
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_top[i] <= t_ptr'(i * SLICE);
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_bnd    <= n_bnd;
            r_top    <= n_top;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_bad <= n_bad;
        r_k   <= n_k;
        r_val <= n_val;
        r_idx <= n_idx;
        r_ptr <= n_ptr;
        r_up  <= n_up;
        r_res <= n_res;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &order_ok)
        else $error("stack bounds and tops out of order");

    a_ends_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bnd[0] == '0) && (r_bnd[NUM_STACKS] == t_ptr'(NUM_STACKS * SLICE)))
        else $error("outer bound moved");

    a_xfer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CHECK) && o_stall)
        else $error("item transfer did not start the sequencer");

    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_MV_WR) || (r_state == S_PUSH))
        else $error("word write outside move or push");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && out_free |=> o_valid && (r_state == S_IDLE))
        else $error("result not loaded on finish");
`endif

endmodule

@@ rtl/sams_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sams_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
